>>> hdl/obrb_pkg.sv
package obrb_pkg;

	// Field and register widths of the ports.
	localparam int CAP_W  = 11;
	localparam int DATA_W = 8;
	localparam int KIND_W = 3;
	localparam int OFS_W  = 10;
	// Width for position sums: a position plus a fill level stays below 4096.
	localparam int ARW    = 12;

	// Defaults for the top-level parameters.
	localparam int DEF_STORE_DEPTH = 1024;
	localparam int DEF_BURST_MAX   = 16;

	// Operation codes.
	localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SKIP  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

	// Advance a ring position; the step never exceeds the capacity, so one
	// compare and subtract wraps it.
	function automatic logic [ARW-1:0] ring_adv(input logic [ARW-1:0] pos,
		input logic [ARW-1:0] by, input logic [CAP_W-1:0] cap);
		logic [ARW-1:0] p;
		p = pos + by;
		if (p >= {1'b0, cap}) begin
			p = p - {1'b0, cap};
		end
		return p;
	endfunction

endpackage

>>> hdl/obrb_store.sv
module obrb_store #(
	parameter int DEPTH = obrb_pkg::DEF_STORE_DEPTH
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  logic [obrb_pkg::DATA_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [obrb_pkg::DATA_W-1:0] rd_data
);
	import obrb_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/overwriting_byte_ring_buffer.sv
// Byte FIFO over a circular store of STORE_DEPTH bytes, of which a configured
// number of slots are in use; writing the capacity empties the buffer. A write,
// skip, clear or unknown operation, or a read or peek with no bytes to return,
// gives one status beat. A read or peek of n bytes (n capped by BURST_MAX and
// the bytes available: the fill level, less the offset for a peek) reads each
// byte through the store's registered read port and then loads it into the
// output register. A new item is taken once the previous one's beats are all
// handed to the output register and the output is not stalled. A write into
// a full buffer drops the oldest byte and flags it on the status beat. Every
// beat reports fill level, full and empty after its own operation.
module overwriting_byte_ring_buffer #(
	parameter int STORE_DEPTH = obrb_pkg::DEF_STORE_DEPTH,
	parameter int BURST_MAX   = obrb_pkg::DEF_BURST_MAX
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write channel.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [obrb_pkg::CAP_W-1:0]  cfg_data,
	// Operation channel.
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [obrb_pkg::KIND_W-1:0] kind,
	input  logic [obrb_pkg::DATA_W-1:0] data_byte,
	input  logic [obrb_pkg::CAP_W-1:0]  count,
	input  logic [obrb_pkg::OFS_W-1:0]  offset,
	// Result channel.
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [obrb_pkg::DATA_W-1:0] byte_out,
	output logic                        byte_valid,
	output logic                        last,
	output logic                        overwrote,
	output logic [obrb_pkg::CAP_W-1:0]  fill_level,
	output logic                        is_full,
	output logic                        buf_empty
);
	import obrb_pkg::*;

	localparam int POS_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(BURST_MAX + 1);
	localparam logic [CAP_W-1:0] CAP_RST =
		CAP_W'((STORE_DEPTH < 1024) ? STORE_DEPTH : 1024);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [CAP_W-1:0]  cap_q, cap_d;
	logic [POS_W-1:0]  wp_q, wp_d, rp_q, rp_d, ptr_q, ptr_d;
	logic [CAP_W-1:0]  fill_q, fill_d;
	logic [CNT_W-1:0]  left_q, left_d;
	logic              pop_q, pop_d;
	logic              out_vld_q;

	logic              out_free, in_acc, cfg_acc, ld;
	logic [DATA_W-1:0] r_byte, rd_data;
	logic              r_vld, r_last, r_ovw;
	logic [CAP_W-1:0]  r_fill, n_cap, n_peek, n_skip, cfg_cap;
	logic              mem_we, mem_re;

	// A configuration beat holds off the operation channel for its cycle.
	assign out_free  = !out_vld_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_free || cfg_valid;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_acc   = cfg_valid && cfg_ready;

	// Capacity written through the port: zero becomes one, saturate at depth.
	assign cfg_cap = (cfg_data == '0) ? CAP_W'(1) :
		((32'(cfg_data) > STORE_DEPTH) ? CAP_W'(STORE_DEPTH) : cfg_data);

	// Burst lengths for the incoming item.
	assign n_cap  = (count > CAP_W'(BURST_MAX)) ? CAP_W'(BURST_MAX) : count;
	assign n_peek = (n_cap > fill_q - {1'b0, offset}) ? fill_q - {1'b0, offset} : n_cap;
	assign n_skip = (count > fill_q) ? fill_q : count;

	// Next-state logic for the ring pointers, the burst sequencer and the result.
	always_comb begin
		state_d = state_q;
		cap_d   = cap_q;
		wp_d    = wp_q;
		rp_d    = rp_q;
		ptr_d   = ptr_q;
		fill_d  = fill_q;
		left_d  = left_q;
		pop_d   = pop_q;
		ld      = 1'b0;
		r_byte  = '0;
		r_vld   = 1'b0;
		r_last  = 1'b1;
		r_ovw   = 1'b0;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cfg_acc) begin
					cap_d  = cfg_cap;
					wp_d   = '0;
					rp_d   = '0;
					fill_d = '0;
				end else if (in_acc) begin
					ld = 1'b1;
					case (kind)
						KIND_WRITE: begin
							mem_we = 1'b1;
							r_ovw  = (fill_q == cap_q);
							if (fill_q == cap_q) begin
								rp_d = POS_W'(ring_adv(ARW'(rp_q), ARW'(1), cap_q));
							end else begin
								fill_d = fill_q + CAP_W'(1);
							end
							wp_d = POS_W'(ring_adv(ARW'(wp_q), ARW'(1), cap_q));
						end
						KIND_READ: begin
							if (n_cap != '0 && fill_q != '0) begin
								ld      = 1'b0;
								pop_d   = 1'b1;
								ptr_d   = rp_q;
								left_d  = CNT_W'((n_cap > fill_q) ? fill_q : n_cap);
								state_d = ST_READ;
							end
						end
						KIND_PEEK: begin
							if (n_cap != '0 && {1'b0, offset} < fill_q) begin
								ld      = 1'b0;
								pop_d   = 1'b0;
								ptr_d   = POS_W'(ring_adv(ARW'(rp_q), ARW'(offset), cap_q));
								left_d  = CNT_W'(n_peek);
								state_d = ST_READ;
							end
						end
						KIND_SKIP: begin
							rp_d   = POS_W'(ring_adv(ARW'(rp_q), ARW'(n_skip), cap_q));
							fill_d = fill_q - n_skip;
						end
						KIND_CLEAR: begin
							wp_d   = '0;
							rp_d   = '0;
							fill_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				mem_re  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					ld     = 1'b1;
					r_byte = rd_data;
					r_vld  = 1'b1;
					r_last = (left_q == CNT_W'(1));
					ptr_d  = POS_W'(ring_adv(ARW'(ptr_q), ARW'(1), cap_q));
					left_d = left_q - CNT_W'(1);
					if (pop_q) begin
						rp_d   = POS_W'(ring_adv(ARW'(ptr_q), ARW'(1), cap_q));
						fill_d = fill_q - CAP_W'(1);
					end
					state_d = (left_q == CNT_W'(1)) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		r_fill = fill_d;
	end

	// Control and ring state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cap_q     <= CAP_RST;
			wp_q      <= '0;
			rp_q      <= '0;
			fill_q    <= '0;
			left_q    <= '0;
			pop_q     <= 1'b0;
			ptr_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cap_q   <= cap_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			fill_q  <= fill_d;
			left_q  <= left_d;
			pop_q   <= pop_d;
			ptr_q   <= ptr_d;
			if (ld) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Output register for one result beat.
	always_ff @(posedge clk) begin
		if (ld) begin
			byte_out   <= r_byte;
			byte_valid <= r_vld;
			last       <= r_last;
			overwrote  <= r_ovw;
			fill_level <= r_fill;
			is_full    <= (r_fill == cap_q);
			buf_empty  <= (r_fill == '0);
		end
	end

	assign out_valid = out_vld_q;

	// Writes happen only in idle and reads only during a burst, so the two
	// ports never touch the same entry in one cycle.
	obrb_store #(
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (wp_q),
		.wr_data (data_byte),
		.rd_en   (mem_re),
		.rd_addr (ptr_q),
		.rd_data (rd_data)
	);

	// The fill level never exceeds the ring size.
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_q) else $error("fill level above capacity");

	// Both positions lie inside the ring.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CAP_W'(wp_q) < cap_q) && (CAP_W'(rp_q) < cap_q))
		else $error("ring position outside capacity");

	// Empty and full rings have coinciding positions.
	a_pos_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == cap_q) |-> (wp_q == rp_q))
		else $error("positions disagree with fill level");

	// A burst never emits with no bytes left.
	a_burst_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_EMIT) |-> (left_q != '0))
		else $error("burst running with zero bytes left");

endmodule
